// ===== sv/kec_pkg.sv =====
// Shared types, codes and tables for the keypad/encoder event controller.
// No dependencies; every other file depends on this package.
package kec_pkg;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int KEY_W    = 3;
  localparam int BTN_W    = 2;
  localparam int PHASE_W  = 2;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;

  // Default for the hold counter width
  localparam int COUNT_WIDTH_DEF = 8;

  // Event kinds
  localparam logic [MODE_W-1:0] MODE_PINS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  // Pending button codes
  localparam logic [BTN_W-1:0] BTN_NONE  = 2'd0;
  localparam logic [BTN_W-1:0] BTN_ENTER = 2'd1;
  localparam logic [BTN_W-1:0] BTN_UP    = 2'd2;
  localparam logic [BTN_W-1:0] BTN_DOWN  = 2'd3;

  // Key codes
  localparam logic [KEY_W-1:0] K_NONE       = 3'd0;
  localparam logic [KEY_W-1:0] K_ENTER      = 3'd1;
  localparam logic [KEY_W-1:0] K_UP         = 3'd2;
  localparam logic [KEY_W-1:0] K_DOWN       = 3'd3;
  localparam logic [KEY_W-1:0] K_LEFT       = 3'd4;
  localparam logic [KEY_W-1:0] K_RIGHT      = 3'd5;
  localparam logic [KEY_W-1:0] K_ENTER_LONG = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PUSH = 1'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 8'd3;
  localparam logic [CFG_W-1:0] LONG_PUSH_RESET = 8'd100;
  localparam logic [PHASE_W-1:0] PHASE_RESET   = 2'd3;

  // Quadrature step per {previous, current} phase pair
  typedef enum logic [1:0] {
    STEP_NONE  = 2'd0,
    STEP_RIGHT = 2'd1,
    STEP_LEFT  = 2'd2
  } step_t;

  localparam step_t STEP_TABLE [16] = '{
    STEP_NONE,  STEP_LEFT,  STEP_RIGHT, STEP_NONE,
    STEP_RIGHT, STEP_NONE,  STEP_NONE,  STEP_LEFT,
    STEP_LEFT,  STEP_NONE,  STEP_NONE,  STEP_RIGHT,
    STEP_NONE,  STEP_RIGHT, STEP_LEFT,  STEP_NONE
  };

  // One input word
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               push_pressed;
    logic               up_pressed;
    logic               down_pressed;
    logic [PHASE_W-1:0] encoder_ab;
  } event_t;

  // One result word
  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic             key_ready;
  } result_t;

  // Controller state apart from the hold counter
  typedef struct packed {
    logic [BTN_W-1:0]   pending_button;
    logic [KEY_W-1:0]   buffered_key;
    logic               buffer_valid;
    logic [PHASE_W-1:0] previous_phases;
  } ctrl_state_t;

  // Encoder decode status
  typedef struct packed {
    logic             post;
    logic [KEY_W-1:0] key;
  } enc_post_t;

endpackage

// ===== sv/kec_if.sv =====
// Valid/ready channel interfaces for event words and result words.
// Depends on kec_pkg for field widths.
interface kec_req_if;
  logic                        valid;
  logic                        ready;
  logic [kec_pkg::MODE_W-1:0]  mode;
  logic                        push_pressed;
  logic                        up_pressed;
  logic                        down_pressed;
  logic [kec_pkg::PHASE_W-1:0] encoder_ab;

  modport source (output valid, mode, push_pressed, up_pressed, down_pressed,
                  encoder_ab, input ready);
  modport sink (input valid, mode, push_pressed, up_pressed, down_pressed,
                encoder_ab, output ready);
endinterface

interface kec_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [kec_pkg::KEY_W-1:0] key_code;
  logic                      key_ready;

  modport source (output valid, key_code, key_ready, input ready);
  modport sink (input valid, key_code, key_ready, output ready);
endinterface

// ===== sv/keypad_encoder_event_controller_core.sv =====
// Keypad and quadrature encoder event controller, top level.
// An accepted event passes through the input register, then the result
// register; one event per cycle unless the output stalls, set by the single
// state update pass. Reset (rst, synchronous) clears the button and key
// state, sets the encoder phases to 3 and loads the register defaults.
module keypad_encoder_event_controller_core #(
  parameter int COUNT_WIDTH = kec_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  kec_req_if.sink                       req,
  kec_rsp_if.source                     rsp,
  input  logic                          write_enable,
  input  logic [kec_pkg::CFG_IDX_W-1:0] write_index,
  input  logic [kec_pkg::CFG_W-1:0]     write_data
);
  import kec_pkg::*;

  logic                   in_valid;
  event_t                 in_word;
  logic                   out_valid;
  result_t                out_word;
  ctrl_state_t            state;
  ctrl_state_t            state_next;
  logic [COUNT_WIDTH-1:0] hold_count;
  logic [COUNT_WIDTH-1:0] hold_count_next;
  result_t                result;
  logic [CFG_W-1:0]       debounce_threshold;
  logic [CFG_W-1:0]       long_push_limit;
  logic                   advance;

  // Pipeline moves whenever the result register is free or being drained
  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !in_valid || advance;

  assign rsp.valid     = out_valid;
  assign rsp.key_code  = out_word.key_code;
  assign rsp.key_ready = out_word.key_ready;

  kec_event_logic #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_logic (
    .evt                (in_word),
    .state              (state),
    .hold_count         (hold_count),
    .debounce_threshold (debounce_threshold),
    .long_push_limit    (long_push_limit),
    .state_next         (state_next),
    .hold_count_next    (hold_count_next),
    .result             (result)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_threshold <= DEBOUNCE_RESET;
      long_push_limit    <= LONG_PUSH_RESET;
    end else if (write_enable) begin
      case (write_index)
        REG_DEBOUNCE:  debounce_threshold <= write_data;
        REG_LONG_PUSH: long_push_limit    <= write_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_word.mode         <= req.mode;
      in_word.push_pressed <= req.push_pressed;
      in_word.up_pressed   <= req.up_pressed;
      in_word.down_pressed <= req.down_pressed;
      in_word.encoder_ab   <= req.encoder_ab;
    end
  end

  // State and result register, updated as a word leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid             <= 1'b0;
      state.pending_button  <= BTN_NONE;
      state.buffered_key    <= K_NONE;
      state.buffer_valid    <= 1'b0;
      state.previous_phases <= PHASE_RESET;
      hold_count            <= '0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        state      <= state_next;
        hold_count <= hold_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_word <= result;
    end
  end
endmodule

// ===== sv/kec_quad_decoder.sv =====
// Quadrature decoder: table lookup on the phase transition, detent check.
// Depends on kec_pkg.
module kec_quad_decoder (
  input  logic [kec_pkg::PHASE_W-1:0] previous_phases,
  input  logic [kec_pkg::PHASE_W-1:0] encoder_ab,
  output kec_pkg::enc_post_t          enc_post
);
  import kec_pkg::*;

  step_t step;

  // Look up the step, then post only when landing on the detent
  always_comb begin
    step = STEP_TABLE[{previous_phases, encoder_ab}];
    enc_post.post = (step != STEP_NONE) && (encoder_ab == PHASE_RESET);
    enc_post.key  = (step == STEP_RIGHT) ? K_RIGHT : K_LEFT;
  end
endmodule

// ===== sv/kec_event_logic.sv =====
// Next-state and result logic for one event word.
// Depends on kec_pkg and kec_quad_decoder.
module kec_event_logic #(
  parameter int COUNT_WIDTH = kec_pkg::COUNT_WIDTH_DEF
) (
  input  kec_pkg::event_t             evt,
  input  kec_pkg::ctrl_state_t        state,
  input  logic [COUNT_WIDTH-1:0]      hold_count,
  input  logic [kec_pkg::CFG_W-1:0]   debounce_threshold,
  input  logic [kec_pkg::CFG_W-1:0]   long_push_limit,
  output kec_pkg::ctrl_state_t        state_next,
  output logic [COUNT_WIDTH-1:0]      hold_count_next,
  output kec_pkg::result_t            result
);
  import kec_pkg::*;

  // Compare width covers both the counter and the 8-bit registers plus a carry
  localparam int CMP_W = ((COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W) + 1;

  enc_post_t        enc_post;
  logic [CMP_W-1:0] hold_ext;
  logic [CMP_W-1:0] limit_ext;
  logic [CMP_W-1:0] thr_ext;
  logic [CMP_W-1:0] cnt_max_ext;
  logic [CMP_W-1:0] hold_sat;
  logic [BTN_W-1:0] pend;
  logic             release_hit;
  logic [KEY_W-1:0] release_key;

  kec_quad_decoder u_quad (
    .previous_phases (state.previous_phases),
    .encoder_ab      (evt.encoder_ab),
    .enc_post        (enc_post)
  );

  assign hold_ext    = CMP_W'(hold_count);
  assign limit_ext   = CMP_W'(long_push_limit);
  assign thr_ext     = CMP_W'(debounce_threshold);
  assign cnt_max_ext = CMP_W'({COUNT_WIDTH{1'b1}});

  // Saturating increment of the hold counter
  always_comb begin
    hold_sat = hold_ext + CMP_W'(1);
    if (hold_sat > limit_ext) hold_sat = limit_ext;
    if (hold_sat > cnt_max_ext) hold_sat = cnt_max_ext;
  end

  always_comb begin
    state_next      = state;
    hold_count_next = hold_count;
    result.key_code = K_NONE;
    pend            = state.pending_button;
    release_hit     = 1'b0;
    release_key     = K_NONE;

    unique case (evt.mode)
      MODE_PINS: begin
        // Latch first pressed button by priority
        if (pend == BTN_NONE) begin
          if (evt.push_pressed) pend = BTN_ENTER;
          else if (evt.up_pressed) pend = BTN_UP;
          else if (evt.down_pressed) pend = BTN_DOWN;
        end
        // Release of the pending button
        if (!evt.push_pressed && pend == BTN_ENTER) begin
          release_hit = 1'b1;
          release_key = K_ENTER;
        end else if (!evt.up_pressed && pend == BTN_UP) begin
          release_hit = 1'b1;
          release_key = K_UP;
        end else if (!evt.down_pressed && pend == BTN_DOWN) begin
          release_hit = 1'b1;
          release_key = K_DOWN;
        end
        if (release_hit) begin
          if (hold_ext > thr_ext) begin
            state_next.buffered_key = release_key;
            state_next.buffer_valid = 1'b1;
          end
          pend = BTN_NONE;
        end
        state_next.pending_button  = pend;
        state_next.previous_phases = evt.encoder_ab;
        // Encoder key wins over a button key posted by the same word
        if (enc_post.post) begin
          state_next.buffered_key = enc_post.key;
          state_next.buffer_valid = 1'b1;
        end
      end
      MODE_TICK: begin
        if (pend != BTN_NONE) hold_count_next = hold_sat[COUNT_WIDTH-1:0];
        else hold_count_next = '0;
        // Long press once enter is held up to the limit
        if (evt.push_pressed && pend == BTN_ENTER &&
            CMP_W'(hold_count_next) == limit_ext) begin
          state_next.buffered_key   = K_ENTER_LONG;
          state_next.buffer_valid   = 1'b1;
          state_next.pending_button = BTN_NONE;
        end
      end
      MODE_READ: begin
        if (state.buffer_valid) begin
          result.key_code         = state.buffered_key;
          state_next.buffer_valid = 1'b0;
        end
      end
      default: begin
        // unused mode: no change
      end
    endcase

    result.key_ready = state_next.buffer_valid;
  end
endmodule
